// File: hw/rtl/pmq_pkg.sv
`default_nettype none
package pmq_pkg;

    localparam int ROT_W = 16;
    localparam int TRANS_W = 32;
    localparam int POS_W = 32;
    localparam int QUAT_W = 16;
    localparam int SCALE_W = 24;
    localparam int NUM_W = 17;
    localparam int RAD_W = 17;
    localparam int ROOT_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // orientation case codes
    localparam logic [1:0] SEL_TRACE = 2'd0;
    localparam logic [1:0] SEL_X = 2'd1;
    localparam logic [1:0] SEL_Y = 2'd2;
    localparam logic [1:0] SEL_Z = 2'd3;

    // classified pose job
    typedef struct packed {
        logic [8:0][ROT_W-1:0]   rot;
        logic [2:0][TRANS_W-1:0] trans;
        logic [1:0]              sel;
        logic [RAD_W-1:0]        rad;
        logic [2:0][NUM_W-1:0]   num_mag;
        logic [2:0]              num_neg;
    } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/pmq_front.sv
`default_nettype none
module pmq_front (
    input  wire logic signed [15:0] rot_00,
    input  wire logic signed [15:0] rot_01,
    input  wire logic signed [15:0] rot_02,
    input  wire logic signed [15:0] rot_10,
    input  wire logic signed [15:0] rot_11,
    input  wire logic signed [15:0] rot_12,
    input  wire logic signed [15:0] rot_20,
    input  wire logic signed [15:0] rot_21,
    input  wire logic signed [15:0] rot_22,
    input  wire logic signed [31:0] trans_x,
    input  wire logic signed [31:0] trans_y,
    input  wire logic signed [31:0] trans_z,
    output pmq_pkg::job_t           job
);

    logic signed [17:0] l0, l1, l2, l4, l5, l6, l8, l9, l10;
    logic signed [17:0] tr;
    logic signed [18:0] rad_s;
    logic signed [17:0] d69, d82, d14, s14, s82, s69;
    logic signed [17:0] num_a, num_b, num_c;
    logic [1:0] sel;

    always_comb
    begin
        l0 = 18'(rot_00);
        l1 = 18'(rot_01);
        l2 = 18'(rot_02);
        l4 = 18'(rot_10);
        l5 = 18'(rot_11);
        l6 = 18'(rot_12);
        l8 = 18'(rot_20);
        l9 = 18'(rot_21);
        l10 = 18'(rot_22);
        tr = l0 + l5 + l10;
        d69 = l6 - l9;
        d82 = l8 - l2;
        d14 = l1 - l4;
        s14 = l1 + l4;
        s82 = l8 + l2;
        s69 = l6 + l9;

        if (tr > 18'sd0)
        begin
            sel = pmq_pkg::SEL_TRACE;
            rad_s = 19'sd16384 + 19'(tr);
        end
        else if (l0 > l5 && l0 > l10)
        begin
            sel = pmq_pkg::SEL_X;
            rad_s = 19'sd16384 + 19'(l0) - 19'(l5) - 19'(l10);
        end
        else if (l5 > l10)
        begin
            sel = pmq_pkg::SEL_Y;
            rad_s = 19'sd16384 + 19'(l5) - 19'(l0) - 19'(l10);
        end
        else
        begin
            sel = pmq_pkg::SEL_Z;
            rad_s = 19'sd16384 + 19'(l10) - 19'(l0) - 19'(l5);
        end

        unique case (sel)
            pmq_pkg::SEL_TRACE:
            begin
                num_a = d69;
                num_b = d82;
                num_c = d14;
            end
            pmq_pkg::SEL_X:
            begin
                num_a = d69;
                num_b = s14;
                num_c = s82;
            end
            pmq_pkg::SEL_Y:
            begin
                num_a = d82;
                num_b = s14;
                num_c = s69;
            end
            default:
            begin
                num_a = d14;
                num_b = s82;
                num_c = s69;
            end
        endcase

        job.rot = {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};
        job.trans = {trans_z, trans_y, trans_x};
        job.sel = sel;
        // negative radicand clamps to zero
        job.rad = rad_s[18] ? '0 : rad_s[16:0];
        job.num_neg = {num_c[17], num_b[17], num_a[17]};
        job.num_mag[0] = num_a[17] ? 17'(-num_a) : num_a[16:0];
        job.num_mag[1] = num_b[17] ? 17'(-num_b) : num_b[16:0];
        job.num_mag[2] = num_c[17] ? 17'(-num_c) : num_c[16:0];
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmq_fifo.sv
`default_nettype none
module pmq_fifo #(
    parameter int DEPTH = pmq_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pmq_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output pmq_pkg::job_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pmq_pkg::job_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmq_div.sv
`default_nettype none
module pmq_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        step,
    input  wire logic [16:0] num_mag,
    input  wire logic [15:0] root,
    output logic [15:0]      quo
);

    logic [32:0] rem_reg, den_reg;
    logic [15:0] quo_reg;
    logic        hold_reg;
    logic [32:0] n_full, lim;
    logic [32:0] rem_v, den_v;
    logic [15:0] quo_v;

    assign quo = quo_reg;

    always_comb
    begin
        // (2n + d) over 2d with n = num << 14, d = 2 * root
        n_full = {1'b0, num_mag, 15'b0} + {16'b0, root, 1'b0};
        lim = {root, 17'b0};
        rem_v = rem_reg;
        den_v = den_reg;
        quo_v = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            if (rem_v >= den_v)
            begin
                rem_v = rem_v - den_v;
                quo_v = {quo_v[14:0], 1'b1};
            end
            else
                quo_v = {quo_v[14:0], 1'b0};
            den_v = {1'b0, den_v[32:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b1;
        else if (start)
            hold_reg <= (root == '0) || (n_full >= lim);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= n_full;
            den_reg <= lim;
            if (root == '0)
                quo_reg <= '0;
            else if (n_full >= lim)
                quo_reg <= 16'h8000;
            else
                quo_reg <= '0;
        end
        else if (step && !hold_reg)
        begin
            rem_reg <= rem_v;
            den_reg <= den_v;
            quo_reg <= quo_v;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/pmq_back.sv
`default_nettype none
module pmq_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    input  wire pmq_pkg::job_t      job,
    output logic                    job_pop,
    input  wire logic [23:0]        scale,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [15:0]      quat_w,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] PH_LAST = 3'd6;
    localparam logic [4:0] QC_SQRT_END = 5'd8;
    localparam logic [4:0] QC_DIV_END = 5'd16;
    localparam logic [4:0] QC_LAST = 5'd17;

    logic [1:0] state_reg;
    logic       pbusy_reg, qbusy_reg, res_valid_reg;
    logic [1:0] prow_reg;
    logic [2:0] pph_reg;
    logic [4:0] qcnt_reg;

    pmq_pkg::job_t      job_reg;
    logic [8:0][15:0]   mrow_reg;
    logic signed [61:0] acc_reg;
    logic signed [35:0] p_reg;
    logic [31:0]        pval_reg [3];
    logic [31:0]        sq_v_reg;
    logic [15:0]        sq_root_reg;
    logic [19:0]        sq_rem_reg;
    logic [15:0]        s_reg;

    logic [31:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [15:0] qw_reg, qx_reg, qy_reg, qz_reg;

    logic start, load_out, div_start, div_step;
    logic signed [18:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [50:0] prod;
    logic signed [61:0] prod62, negv, rv;
    logic [45:0] r46;
    logic [31:0] pos_sat;
    logic [31:0] sq_v_n;
    logic [15:0] sq_root_n;
    logic [19:0] sq_rem_n, sq_shift, sq_trial;
    logic [16:0] s_sum;
    logic [15:0] s_calc, quarter;
    logic [15:0] quo [3];
    logic [15:0] comp_w, comp_x, comp_y, comp_z;

    function automatic logic [15:0] fmt_w(input logic neg, input logic [15:0] mag);
        logic [15:0] r;
        if (neg)
            r = 16'(-mag);
        else
            r = (mag > 16'd32767) ? 16'd32767 : mag;
        return r;
    endfunction

    function automatic logic [15:0] fmt_v(input logic neg, input logic [15:0] mag);
        logic [15:0] m;
        m = (mag > 16'd32767) ? 16'd32767 : mag;
        return neg ? m : 16'(-m);
    endfunction

    assign start = (state_reg == ST_IDLE) && job_valid;
    assign job_pop = start;
    assign load_out = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);
    assign div_start = qbusy_reg && (qcnt_reg == QC_SQRT_END);
    assign div_step = qbusy_reg && (qcnt_reg > QC_SQRT_END) && (qcnt_reg <= QC_DIV_END);

    // shared position multiplier
    always_comb
    begin
        case (pph_reg)
            3'd0:
            begin
                mul_a = 19'(signed'(mrow_reg[0]));
                mul_b = job_reg.trans[0];
            end
            3'd1:
            begin
                mul_a = 19'(signed'(mrow_reg[1]));
                mul_b = job_reg.trans[1];
            end
            3'd2:
            begin
                mul_a = 19'(signed'(mrow_reg[2]));
                mul_b = job_reg.trans[2];
            end
            3'd4:
            begin
                mul_a = {1'b0, p_reg[17:0]};
                mul_b = {8'b0, scale};
            end
            default:
            begin
                mul_a = {p_reg[35], p_reg[35:18]};
                mul_b = {8'b0, scale};
            end
        endcase
        prod = mul_a * mul_b;
        prod62 = 62'(prod);
        negv = -acc_reg + 62'sd8192;
        rv = acc_reg + 62'sd32768;
        r46 = rv[61:16];
        if (!r46[45] && (r46[44:31] != '0))
            pos_sat = 32'h7FFF_FFFF;
        else if (r46[45] && (r46[44:31] != '1))
            pos_sat = 32'h8000_0000;
        else
            pos_sat = r46[31:0];
    end

    // square root, two result bits a cycle
    always_comb
    begin
        sq_v_n = sq_v_reg;
        sq_root_n = sq_root_reg;
        sq_rem_n = sq_rem_reg;
        sq_shift = '0;
        sq_trial = '0;
        for (int i = 0; i < 2; i++)
        begin
            sq_shift = {sq_rem_n[17:0], sq_v_n[31:30]};
            sq_trial = {2'b0, sq_root_n, 2'b01};
            sq_v_n = {sq_v_n[29:0], 2'b0};
            if (sq_shift >= sq_trial)
            begin
                sq_rem_n = sq_shift - sq_trial;
                sq_root_n = {sq_root_n[14:0], 1'b1};
            end
            else
            begin
                sq_rem_n = sq_shift;
                sq_root_n = {sq_root_n[14:0], 1'b0};
            end
        end
        // round to nearest
        s_sum = {1'b0, sq_root_reg} + ((sq_rem_reg > {4'b0, sq_root_reg}) ? 17'd1 : 17'd0);
        s_calc = s_sum[15:0];
        quarter = 16'(({1'b0, s_reg} + 17'd1) >> 1);
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        pmq_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (div_start),
            .step    (div_step),
            .num_mag (job_reg.num_mag[g]),
            .root    (s_calc),
            .quo     (quo[g])
        );
    end

    // lane to component routing per case
    always_comb
    begin
        unique case (job_reg.sel)
            pmq_pkg::SEL_TRACE:
            begin
                comp_w = fmt_w(1'b0, quarter);
                comp_x = fmt_v(job_reg.num_neg[0], quo[0]);
                comp_y = fmt_v(job_reg.num_neg[1], quo[1]);
                comp_z = fmt_v(job_reg.num_neg[2], quo[2]);
            end
            pmq_pkg::SEL_X:
            begin
                comp_w = fmt_w(job_reg.num_neg[0], quo[0]);
                comp_x = fmt_v(1'b0, quarter);
                comp_y = fmt_v(job_reg.num_neg[1], quo[1]);
                comp_z = fmt_v(job_reg.num_neg[2], quo[2]);
            end
            pmq_pkg::SEL_Y:
            begin
                comp_w = fmt_w(job_reg.num_neg[0], quo[0]);
                comp_x = fmt_v(job_reg.num_neg[1], quo[1]);
                comp_y = fmt_v(1'b0, quarter);
                comp_z = fmt_v(job_reg.num_neg[2], quo[2]);
            end
            default:
            begin
                comp_w = fmt_w(job_reg.num_neg[0], quo[0]);
                comp_x = fmt_v(job_reg.num_neg[1], quo[1]);
                comp_y = fmt_v(job_reg.num_neg[2], quo[2]);
                comp_z = fmt_v(1'b0, quarter);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pbusy_reg <= 1'b0;
            qbusy_reg <= 1'b0;
            prow_reg <= '0;
            pph_reg <= '0;
            qcnt_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                        state_reg <= ST_RUN;
                ST_RUN:
                    if (!pbusy_reg && !qbusy_reg)
                        state_reg <= ST_DONE;
                ST_DONE:
                    if (load_out)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase

            if (start)
            begin
                pbusy_reg <= 1'b1;
                prow_reg <= '0;
                pph_reg <= '0;
            end
            else if (pbusy_reg)
            begin
                if (pph_reg == PH_LAST)
                begin
                    pph_reg <= '0;
                    if (prow_reg == 2'd2)
                        pbusy_reg <= 1'b0;
                    else
                        prow_reg <= prow_reg + 1'b1;
                end
                else
                    pph_reg <= pph_reg + 1'b1;
            end

            if (start)
            begin
                qbusy_reg <= 1'b1;
                qcnt_reg <= '0;
            end
            else if (qbusy_reg)
            begin
                if (qcnt_reg == QC_LAST)
                    qbusy_reg <= 1'b0;
                else
                    qcnt_reg <= qcnt_reg + 1'b1;
            end

            if (load_out)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
            mrow_reg <= job.rot;
            sq_v_reg <= {1'b0, job.rad, 14'b0};
            sq_root_reg <= '0;
            sq_rem_reg <= '0;
        end
        else
        begin
            if (pbusy_reg)
            begin
                case (pph_reg)
                    3'd0:    acc_reg <= prod62;
                    3'd1:    acc_reg <= acc_reg + prod62;
                    3'd2:    acc_reg <= acc_reg + prod62;
                    3'd3:    p_reg <= negv[49:14];
                    3'd4:    acc_reg <= prod62;
                    3'd5:    acc_reg <= acc_reg + {prod62[43:0], 18'b0};
                    default:
                    begin
                        pval_reg[prow_reg] <= pos_sat;
                        mrow_reg <= {48'b0, mrow_reg[8:3]};
                    end
                endcase
            end
            if (qbusy_reg && (qcnt_reg < QC_SQRT_END))
            begin
                sq_v_reg <= sq_v_n;
                sq_root_reg <= sq_root_n;
                sq_rem_reg <= sq_rem_n;
            end
            if (div_start)
                s_reg <= s_calc;
        end

        if (load_out)
        begin
            pos_x_reg <= pval_reg[0];
            pos_y_reg <= pval_reg[1];
            pos_z_reg <= pval_reg[2];
            qw_reg <= comp_w;
            qx_reg <= comp_x;
            qy_reg <= comp_y;
            qz_reg <= comp_z;
        end
    end

    assign res_valid = res_valid_reg;
    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;
    assign quat_w = qw_reg;
    assign quat_x = qx_reg;
    assign quat_y = qy_reg;
    assign quat_z = qz_reg;

endmodule
`default_nettype wire

// File: hw/rtl/pose_matrix_to_position_quaternion.sv
`default_nettype none
// channel   handshake                 payload
// req       req_valid / req_stall     rot_00..rot_22, trans_x/y/z
// res       res_valid / res_stall     pos_x/y/z, quat_w/x/y/z
// cfg       cfg_valid / cfg_ready     cfg_data (scale_factor, q8.16)
//
// per pose the back end pops the queue from idle, then the single shared multiplier
// walks three rows of seven steps, the block leaves run and loads the result register;
// the square root and three dividers finish inside the rows
// a queue of QUEUE_DEPTH poses decouples request acceptance from the back end
// reset is asynchronous, active low; scale_factor resets to 1.0
// a stalled result holds in the output register while the back end starts the next pose
module pose_matrix_to_position_quaternion #(
    parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic signed [15:0] rot_00,
    input  wire logic signed [15:0] rot_01,
    input  wire logic signed [15:0] rot_02,
    input  wire logic signed [15:0] rot_10,
    input  wire logic signed [15:0] rot_11,
    input  wire logic signed [15:0] rot_12,
    input  wire logic signed [15:0] rot_20,
    input  wire logic signed [15:0] rot_21,
    input  wire logic signed [15:0] rot_22,
    input  wire logic signed [31:0] trans_x,
    input  wire logic signed [31:0] trans_y,
    input  wire logic signed [31:0] trans_z,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [31:0]      pos_x,
    output logic signed [31:0]      pos_y,
    output logic signed [31:0]      pos_z,
    output logic signed [15:0]      quat_w,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [23:0]        cfg_data
);

    // scene scale register
    logic [23:0] scale_reg;

    pmq_pkg::job_t front_job, head_job;
    logic q_full, q_not_empty, q_pop, push;

    assign cfg_ready = 1'b1;
    assign req_stall = q_full;
    assign push = req_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= pmq_pkg::SCALE_RESET;
        else if (cfg_valid && cfg_ready)
            scale_reg <= cfg_data;
    end

    // classify: orientation case, radicand and numerators
    pmq_front u_front (
        .rot_00  (rot_00),
        .rot_01  (rot_01),
        .rot_02  (rot_02),
        .rot_10  (rot_10),
        .rot_11  (rot_11),
        .rot_12  (rot_12),
        .rot_20  (rot_20),
        .rot_21  (rot_21),
        .rot_22  (rot_22),
        .trans_x (trans_x),
        .trans_y (trans_y),
        .trans_z (trans_z),
        .job     (front_job)
    );

    // job queue between front and back
    pmq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    // position, square root, divisions and result register
    pmq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .job_pop   (q_pop),
        .scale     (scale_reg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z)
    );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    // one pose request: rot[0..8] = rot_00, rot_01, rot_02, rot_10 .. rot_22
    typedef logic [8:0][pmq_pkg::ROT_W-1:0]   rot_t;
    typedef logic [2:0][pmq_pkg::TRANS_W-1:0] trans_t;

    typedef struct packed {
        logic [2:0][pmq_pkg::POS_W-1:0]  pos;
        logic [3:0][pmq_pkg::QUAT_W-1:0] quat;   // w, x, y, z at index 0..3
    } pose_res_t;

    typedef struct packed {
        rot_t      rot;
        trans_t    trans;
        logic      typed;   // expected result written by hand
        pose_res_t res;
    } pose_row_t;

    localparam int PERIOD_HI = 6;
    localparam int PERIOD_LO = 6;
    localparam int DRAIN_CYCLES = 60;       // margin for the back end plus a two deep queue
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_SCALE = 200;

    localparam logic [15:0] Q_ONE = 16'd16384;
    localparam rot_t ID_ROT = {Q_ONE, 16'd0, 16'd0, 16'd0, Q_ONE, 16'd0, 16'd0, 16'd0, Q_ONE};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    rot_t rot_q = '0;
    trans_t trans_q = '0;
    logic res_valid;
    logic res_stall = 1'b1;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pmq_pkg::SCALE_W-1:0] cfg_data = '0;

    // scale as the block should hold it, written on each accepted cfg request
    logic [pmq_pkg::SCALE_W-1:0] scale_model = pmq_pkg::SCALE_RESET;

    // hand-written expectation riding with the current request
    logic      cur_typed = 1'b0;
    pose_res_t cur_typed_res = '0;

    pose_res_t pose_q[$];
    pose_row_t dir_rows[$];

    int err_cnt = 0;
    int req_cnt = 0;
    int res_cnt = 0;
    int idle_cnt = 0;
    bit no_gaps = 1'b0;     // stretches where neither side idles

    always
    begin
        #PERIOD_HI clk = 1'b1;
        #PERIOD_LO clk = 1'b0;
    end

    pose_matrix_to_position_quaternion DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .rot_00(rot_q[0]),
        .rot_01(rot_q[1]),
        .rot_02(rot_q[2]),
        .rot_10(rot_q[3]),
        .rot_11(rot_q[4]),
        .rot_12(rot_q[5]),
        .rot_20(rot_q[6]),
        .rot_21(rot_q[7]),
        .rot_22(rot_q[8]),
        .trans_x(trans_q[0]),
        .trans_y(trans_q[1]),
        .trans_z(trans_q[2]),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    function automatic longint clamp(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // num * 2^14 / den, nearest with ties away from zero
    function automatic longint q14_div(longint num, longint den);
        longint n;
        longint q;
        if (den <= 0)
            return 0;
        n = (num < 0 ? -num : num) * 16384;
        q = (2 * n + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    // square root rounded to nearest
    function automatic longint root_nearest(longint v);
        longint s;
        s = 0;
        for (int k = 17; k >= 0; k--)
        begin
            if ((s | (longint'(1) <<< k)) * (s | (longint'(1) <<< k)) <= v)
                s = s | (longint'(1) <<< k);
        end
        if (v - s * s > s)
            s = s + 1;
        return s;
    endfunction

    function automatic pose_res_t listener_pose(rot_t m, trans_t t,
                                                logic [pmq_pkg::SCALE_W-1:0] sc);
        pose_res_t r;
        longint e[9];
        longint tv[3];
        longint sum, p, v, tr, rad, s, w, quarter;
        longint q[4];   // w, x, y, z before conjugation
        for (int i = 0; i < 9; i++)
            e[i] = longint'($signed(m[i]));
        for (int i = 0; i < 3; i++)
            tv[i] = longint'($signed(t[i]));

        // negated rotated translation, rounded, then scaled, rounded again and saturated
        for (int row = 0; row < 3; row++)
        begin
            sum = e[3*row] * tv[0] + e[3*row+1] * tv[1] + e[3*row+2] * tv[2];
            p = (-sum + 8192) >>> 14;
            v = (p * longint'(sc) + 32768) >>> 16;
            r.pos[row] = 32'(clamp(v, 32));
        end

        // e[0]=L0 e[1]=L1 e[2]=L2 e[3]=L4 e[4]=L5 e[5]=L6 e[6]=L8 e[7]=L9 e[8]=L10
        tr = e[0] + e[4] + e[8];
        if (tr > 0)
            rad = 16384 + tr;
        else if (e[0] > e[4] && e[0] > e[8])
            rad = 16384 + e[0] - e[4] - e[8];
        else if (e[4] > e[8])
            rad = 16384 + e[4] - e[0] - e[8];
        else
            rad = 16384 + e[8] - e[0] - e[4];
        if (rad < 0)
            rad = 0;
        s = root_nearest(rad * 16384);
        w = 2 * s;
        quarter = (s + 1) >>> 1;

        if (tr > 0)
        begin
            q[0] = quarter;
            q[1] = q14_div(e[5] - e[7], w);
            q[2] = q14_div(e[6] - e[2], w);
            q[3] = q14_div(e[1] - e[3], w);
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            q[0] = q14_div(e[5] - e[7], w);
            q[1] = quarter;
            q[2] = q14_div(e[1] + e[3], w);
            q[3] = q14_div(e[6] + e[2], w);
        end
        else if (e[4] > e[8])
        begin
            q[0] = q14_div(e[6] - e[2], w);
            q[1] = q14_div(e[1] + e[3], w);
            q[2] = quarter;
            q[3] = q14_div(e[5] + e[7], w);
        end
        else
        begin
            q[0] = q14_div(e[1] - e[3], w);
            q[1] = q14_div(e[6] + e[2], w);
            q[2] = q14_div(e[5] + e[7], w);
            q[3] = quarter;
        end

        // inverse of a unit quaternion: keep w, negate the vector part
        r.quat[0] = 16'(clamp(q[0], 16));
        for (int i = 1; i < 4; i++)
            r.quat[i] = 16'(clamp(-clamp(q[i], 16), 16));
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        err_cnt++;
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 res_cnt, field, got, want);
    endtask

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(9, 0);
    endfunction

    // rotation entry: extremes, unit-ish values, or anything
    function automatic logic [15:0] draw_rot();
        case ($urandom_range(5, 0))
            0: return $urandom_range(1, 0) ? 16'h7fff : 16'h8000;
            1: return $urandom_range(1, 0) ? Q_ONE : -Q_ONE;
            2, 3: return 16'($signed($urandom_range(32768, 0)) - 16384);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] draw_trans();
        case ($urandom_range(3, 0))
            0: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
            1: return 32'($signed($urandom_range(32'h00200000, 0)) - 32'sh00100000);
            default: return $urandom();
        endcase
    endfunction

    // one request: optional idle gap, then hold until accepted
    task automatic send_pose(rot_t m, trans_t t, logic typed, pose_res_t res);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rot_q <= m;
        trans_q <= t;
        cur_typed <= typed;
        cur_typed_res <= res;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic write_scale(logic [pmq_pkg::SCALE_W-1:0] value);
        // block must be idle: let the queue drain first
        req_valid <= 1'b0;
        wait (pose_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic pose_res_t mk_res(longint px, longint py, longint pz,
                                         longint qw, longint qx, longint qy, longint qz);
        pose_res_t r;
        r.pos[0] = 32'(px);
        r.pos[1] = 32'(py);
        r.pos[2] = 32'(pz);
        r.quat[0] = 16'(qw);
        r.quat[1] = 16'(qx);
        r.quat[2] = 16'(qy);
        r.quat[3] = 16'(qz);
        return r;
    endfunction

    function automatic trans_t mk_trans(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        trans_t t;
        t[0] = x;
        t[1] = y;
        t[2] = z;
        return t;
    endfunction

    // request and result monitors; inputs are stable before the edge's updates
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
        begin
            req_cnt++;
            if (cur_typed)
                pose_q.push_back(cur_typed_res);
            else
                pose_q.push_back(listener_pose(rot_q, trans_q, scale_model));
        end
        if (rst_n && cfg_valid && cfg_ready)
            scale_model <= cfg_data;
    end

    int hold_cnt = 0;
    always @(posedge clk)
    begin
        pose_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            res_cnt++;
            if (pose_q.size() == 0)
            begin
                err_cnt++;
                $display("result %0d arrived with nothing expected", res_cnt);
            end
            else
            begin
                want = pose_q.pop_front();
                if (pos_x !== $signed(want.pos[0]))
                    report("pos_x", pos_x, $signed(want.pos[0]));
                if (pos_y !== $signed(want.pos[1]))
                    report("pos_y", pos_y, $signed(want.pos[1]));
                if (pos_z !== $signed(want.pos[2]))
                    report("pos_z", pos_z, $signed(want.pos[2]));
                if (quat_w !== $signed(want.quat[0]))
                    report("quat_w", quat_w, $signed(want.quat[0]));
                if (quat_x !== $signed(want.quat[1]))
                    report("quat_x", quat_x, $signed(want.quat[1]));
                if (quat_y !== $signed(want.quat[2]))
                    report("quat_y", quat_y, $signed(want.quat[2]));
                if (quat_z !== $signed(want.quat[3]))
                    report("quat_z", quat_z, $signed(want.quat[3]));
            end
            hold_cnt = draw_gap();
        end
        // receiver back-pressure: stall for the drawn number of cycles
        if (hold_cnt > 0)
        begin
            res_stall <= 1'b1;
            hold_cnt--;
        end
        else
            res_stall <= 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [pmq_pkg::SCALE_W-1:0] scales[6];
        rot_t m;
        trans_t t;
        pose_res_t none;
        int phase_items;

        none = '0;
        scales[0] = 24'd0;
        scales[1] = 24'hffffff;
        scales[2] = 24'd1;
        scales[3] = 24'($urandom());
        scales[4] = 24'd32768;
        scales[5] = pmq_pkg::SCALE_RESET;

        // directed poses, run at the reset scale of 1.0
        // identity at origin: quat_w = 1.0, rest zero
        dir_rows.push_back({ID_ROT, mk_trans(0, 0, 0), 1'b1, mk_res(0, 0, 0, 16384, 0, 0, 0)});
        // identity moves the listener by minus the translation
        dir_rows.push_back({ID_ROT, mk_trans(32'h10000, 32'h20000, 32'hfffd0000), 1'b1,
                            mk_res(-65536, -131072, 196608, 16384, 0, 0, 0)});
        // negating the most negative translation saturates high
        dir_rows.push_back({ID_ROT, mk_trans(32'h80000000, 32'h7fffffff, 0), 1'b1,
                            mk_res(32'h7fffffff, -32'sh7fffffff, 0, 16384, 0, 0, 0)});
        // zero matrix: trace not positive, last-diagonal case, zero positions
        dir_rows.push_back({rot_t'(0), mk_trans(32'h7fffffff, 32'h80000000, 32'h12345678),
                            1'b1, mk_res(0, 0, 0, 0, 0, 0, -8192)});
        // 180 degrees about x, y and z: each largest-diagonal case
        dir_rows.push_back({{-Q_ONE, 16'd0, 16'd0, 16'd0, -Q_ONE, 16'd0, 16'd0, 16'd0, Q_ONE},
                            mk_trans(0, 0, 0), 1'b0, none});
        dir_rows.push_back({{-Q_ONE, 16'd0, 16'd0, 16'd0, Q_ONE, 16'd0, 16'd0, 16'd0, -Q_ONE},
                            mk_trans(0, 0, 0), 1'b0, none});
        dir_rows.push_back({{Q_ONE, 16'd0, 16'd0, 16'd0, -Q_ONE, 16'd0, 16'd0, 16'd0, -Q_ONE},
                            mk_trans(32'h30000, 32'h4000, 32'hffff8000), 1'b0, none});
        // 90 degrees about each axis
        dir_rows.push_back({{Q_ONE, 16'd0, 16'd0, 16'd0, 16'd0, Q_ONE, 16'd0, -Q_ONE, 16'd0},
                            mk_trans(32'h10000, 32'h10000, 32'h10000), 1'b0, none});
        dir_rows.push_back({{16'd0, 16'd0, -Q_ONE, 16'd0, Q_ONE, 16'd0, Q_ONE, 16'd0, 16'd0},
                            mk_trans(32'h10000, 0, 0), 1'b0, none});
        dir_rows.push_back({{16'd0, Q_ONE, 16'd0, -Q_ONE, 16'd0, 16'd0, 16'd0, 16'd0, Q_ONE},
                            mk_trans(0, 32'h10000, 0), 1'b0, none});
        // all entries at the extremes: saturating positions and quotients
        dir_rows.push_back({{9{16'h7fff}}, mk_trans(32'h7fffffff, 32'h7fffffff, 32'h7fffffff),
                            1'b0, none});
        dir_rows.push_back({{9{16'h8000}}, mk_trans(32'h80000000, 32'h80000000, 32'h80000000),
                            1'b0, none});
        dir_rows.push_back({{9{16'h8000}}, mk_trans(32'h7fffffff, 32'h80000000, 32'h7fffffff),
                            1'b0, none});
        // not a rotation: extreme diagonal and off-diagonal entries
        dir_rows.push_back({{16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                             16'h7fff, 16'h7fff, 16'h7fff}, mk_trans(1, 2, 3), 1'b0, none});
        // not a rotation: mixed off-diagonal entries, one diagonal entry at minus one
        dir_rows.push_back({{16'd0, 16'h1234, 16'h4000, 16'hc000, 16'd0, 16'h0100,
                             16'h0200, 16'h0300, -Q_ONE}, mk_trans(0, 0, 0), 1'b0, none});
        // half-LSB rounding on the translation
        dir_rows.push_back({{16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'hffff},
                            mk_trans(32'h2000, 32'hffffe000, 32'h6000), 1'b0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_pose(dir_rows[i].rot, dir_rows[i].trans, dir_rows[i].typed, dir_rows[i].res);

        // random poses under each scale setting, zero and full scale among them
        foreach (scales[s])
        begin
            write_scale(scales[s]);
            phase_items = 0;
            while (phase_items < ITEMS_PER_SCALE)
            begin
                if (phase_items % 40 == 0)
                    no_gaps = ($urandom_range(3, 0) == 0);
                for (int i = 0; i < 9; i++)
                    m[i] = draw_rot();
                for (int i = 0; i < 3; i++)
                    t[i] = draw_trans();
                send_pose(m, t, 1'b0, none);
                phase_items++;
            end
        end
        req_valid <= 1'b0;
        no_gaps = 1'b0;

        wait (pose_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d poses and %0d results over %0d scale settings",
                 req_cnt, res_cnt, 6);
        $display("directed: identity, axis turns, every diagonal case, saturation, rounding");
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pmq_pkg.sv
hw/rtl/pmq_front.sv
hw/rtl/pmq_fifo.sv
hw/rtl/pmq_div.sv
hw/rtl/pmq_back.sv
hw/rtl/pose_matrix_to_position_quaternion.sv
tb/sv/testbench.sv
